@@ design/i2c_register_transaction_sequencer_unit_macros.svh @@
// Assertion macros shared by the I2C register transaction sequencer.
// Used by the top level only; no other dependencies.
`ifndef I2C_REGISTER_TRANSACTION_SEQUENCER_UNIT_MACROS_SVH
`define I2C_REGISTER_TRANSACTION_SEQUENCER_UNIT_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define I2CRTS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked while out of reset.
`define I2CRTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/i2crts_pkg.sv @@
// Package for the I2C register transaction sequencer: item types, codes, constants.
// No dependencies; every other module and interface file of the block imports it.
`timescale 1ns / 1ps

package i2crts_pkg;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDE_ADDR_SLAVE = 1'b1;

    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
    localparam logic [7:0]  WIDE_RESET    = 8'd160;
    localparam logic [7:0]  READ_BIT      = 8'b0000_0001;

    typedef enum logic [1:0] {
        KIND_REQ  = 2'd0,
        KIND_TX   = 2'd1,
        KIND_DONE = 2'd2,
        KIND_TICK = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        CMD_WAIT_IDLE = 3'd0,
        CMD_START     = 3'd1,
        CMD_RESTART   = 3'd2,
        CMD_SEND      = 3'd3,
        CMD_RECV      = 3'd4,
        CMD_ACK       = 3'd5,
        CMD_STOP      = 3'd6
    } cmd_t;

    typedef enum logic [3:0] {
        ERR_OK      = 4'd0,
        ERR_IDLE    = 4'd1,
        ERR_START   = 4'd2,
        ERR_ADDR_W  = 4'd3,
        ERR_REG     = 4'd4,
        ERR_DATA    = 4'd5,
        ERR_STOP    = 4'd6,
        ERR_RESTART = 4'd7,
        ERR_ADDR_R  = 4'd8,
        ERR_RX      = 4'd9
    } err_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  slave_addr;
        logic [15:0] reg_addr;
        logic [7:0]  length;
        logic        is_read;
        logic [7:0]  tx_data;
        logic        ack_received;
        logic [7:0]  rx_data;
    } in_item_t;

    typedef struct packed {
        logic       cmd_valid;
        cmd_t       cmd;
        logic [7:0] cmd_byte;
        logic       ack_value;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic       done_res;
        err_t       error_code;
    } out_item_t;

    typedef struct packed {
        logic [15:0] timeout_ticks;
        logic [7:0]  wide_addr_slave;
    } cfg_t;

    typedef struct packed {
        logic      valid;
        out_item_t item;
    } step_t;

endpackage

@@ design/i2crts_if.sv @@
// Valid/ready channel interfaces for the sequencer's event input and result output.
// Depends on i2crts_pkg for the payload types.
`timescale 1ns / 1ps

interface i2crts_evt_if
    import i2crts_pkg::*;
();
    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface i2crts_res_if
    import i2crts_pkg::*;
();
    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ design/i2crts_cfg.sv @@
// Configuration register file: timeout budget and wide-address slave.
// Depends on i2crts_pkg.
`timescale 1ns / 1ps

module i2crts_cfg
    import i2crts_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                  cfg
);

    logic [15:0] timeout_reg;
    logic [7:0]  wide_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
            wide_reg    <= WIDE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TIMEOUT_TICKS:   timeout_reg <= cfg_wdata;
                CFG_WIDE_ADDR_SLAVE: wide_reg    <= cfg_wdata[7:0];
            endcase
        end
    end

    assign cfg.timeout_ticks   = timeout_reg;
    assign cfg.wide_addr_slave = wide_reg;

endmodule

@@ design/i2crts_fsm.sv @@
// Transaction state machine: reacts to one accepted event and forms at most one result.
// Depends on i2crts_pkg.
`timescale 1ns / 1ps

module i2crts_fsm
    import i2crts_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     accept,
    input  in_item_t evt,
    input  cfg_t     cfg,
    output step_t    step,
    output logic     busy
);

    typedef enum logic [3:0] {
        PH_IDLE, PH_WAIT_IDLE, PH_START, PH_ADDR_W, PH_REG_HI, PH_REG_LO,
        PH_DATA_W, PH_RESTART, PH_ADDR_R, PH_RX, PH_ACK, PH_STOP
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [15:0] ticks_reg, ticks_next;
    logic [7:0]  count_reg, count_next;
    logic [7:0]  total_reg, total_next;
    logic [7:0]  slave_reg, slave_next;
    logic [15:0] reg_addr_reg, reg_addr_next;
    logic        read_reg, read_next;
    logic        wait_ack_reg, wait_ack_next;
    logic [7:0]  count_inc;
    logic        rx_last;
    err_t        phase_err;

    // Error code reported when the transaction dies in the current phase.
    always_comb
    begin
        unique case (phase_reg)
            PH_WAIT_IDLE:        phase_err = ERR_IDLE;
            PH_START:            phase_err = ERR_START;
            PH_ADDR_W:           phase_err = ERR_ADDR_W;
            PH_REG_HI, PH_REG_LO: phase_err = ERR_REG;
            PH_DATA_W:           phase_err = ERR_DATA;
            PH_RESTART:          phase_err = ERR_RESTART;
            PH_ADDR_R:           phase_err = ERR_ADDR_R;
            PH_RX, PH_ACK:       phase_err = ERR_RX;
            PH_STOP:             phase_err = ERR_STOP;
            default:             phase_err = ERR_OK;
        endcase
    end

    assign busy      = (phase_reg != PH_IDLE);
    assign count_inc = count_reg + 8'd1;
    // The last-byte test for NACK compares without wrapping the count.
    assign rx_last   = ({1'b0, count_reg} + 9'd1) >= {1'b0, total_reg};

    always_comb
    begin
        phase_next    = phase_reg;
        ticks_next    = ticks_reg;
        count_next    = count_reg;
        total_next    = total_reg;
        slave_next    = slave_reg;
        reg_addr_next = reg_addr_reg;
        read_next     = read_reg;
        wait_ack_next = wait_ack_reg;
        step          = '0;

        if (accept)
        begin
            unique case (evt.kind)
                KIND_REQ:
                begin
                    if (!busy)
                    begin
                        slave_next    = evt.slave_addr;
                        reg_addr_next = evt.reg_addr;
                        total_next    = evt.length;
                        read_next     = evt.is_read;
                        count_next    = '0;
                        wait_ack_next = 1'b0;
                        ticks_next    = cfg.timeout_ticks;
                        phase_next    = PH_WAIT_IDLE;
                        step.valid          = 1'b1;
                        step.item.cmd_valid = 1'b1;
                        step.item.cmd       = CMD_WAIT_IDLE;
                    end
                end
                KIND_TICK:
                begin
                    if (busy)
                    begin
                        if (ticks_reg <= 16'd1)
                        begin
                            ticks_next    = '0;
                            phase_next    = PH_IDLE;
                            wait_ack_next = 1'b0;
                            step.valid           = 1'b1;
                            step.item.done_res   = 1'b1;
                            step.item.error_code = phase_err;
                        end
                        else
                        begin
                            ticks_next = ticks_reg - 16'd1;
                        end
                    end
                end
                KIND_TX:
                begin
                    if (phase_reg == PH_DATA_W && !wait_ack_reg)
                    begin
                        wait_ack_next       = 1'b1;
                        step.valid          = 1'b1;
                        step.item.cmd_valid = 1'b1;
                        step.item.cmd       = CMD_SEND;
                        step.item.cmd_byte  = evt.tx_data;
                    end
                end
                KIND_DONE:
                begin
                    step.valid          = 1'b1;
                    step.item.cmd_valid = 1'b1;
                    unique case (phase_reg)
                        PH_WAIT_IDLE:
                        begin
                            phase_next    = PH_START;
                            step.item.cmd = CMD_START;
                        end
                        PH_START:
                        begin
                            phase_next         = PH_ADDR_W;
                            step.item.cmd      = CMD_SEND;
                            step.item.cmd_byte = slave_reg;
                        end
                        PH_ADDR_W, PH_REG_HI:
                        begin
                            step.item.cmd = CMD_SEND;
                            if (phase_reg == PH_ADDR_W && slave_reg == cfg.wide_addr_slave)
                            begin
                                phase_next         = PH_REG_HI;
                                step.item.cmd_byte = reg_addr_reg[15:8];
                            end
                            else
                            begin
                                phase_next         = PH_REG_LO;
                                step.item.cmd_byte = reg_addr_reg[7:0];
                            end
                        end
                        PH_REG_LO:
                        begin
                            if (read_reg)
                            begin
                                phase_next    = PH_RESTART;
                                step.item.cmd = CMD_RESTART;
                            end
                            else if (total_reg == 8'd0)
                            begin
                                phase_next    = PH_STOP;
                                step.item.cmd = CMD_STOP;
                            end
                            else
                            begin
                                phase_next    = PH_DATA_W;
                                wait_ack_next = 1'b0;
                                step          = '0;
                            end
                        end
                        PH_DATA_W:
                        begin
                            step = '0;
                            if (wait_ack_reg && evt.ack_received)
                            begin
                                count_next    = count_inc;
                                wait_ack_next = 1'b0;
                                if (count_inc >= total_reg)
                                begin
                                    phase_next          = PH_STOP;
                                    step.valid          = 1'b1;
                                    step.item.cmd_valid = 1'b1;
                                    step.item.cmd       = CMD_STOP;
                                end
                            end
                        end
                        PH_RESTART:
                        begin
                            phase_next         = PH_ADDR_R;
                            step.item.cmd      = CMD_SEND;
                            step.item.cmd_byte = slave_reg | READ_BIT;
                        end
                        PH_ADDR_R:
                        begin
                            if (total_reg == 8'd0)
                            begin
                                phase_next    = PH_STOP;
                                step.item.cmd = CMD_STOP;
                            end
                            else
                            begin
                                phase_next    = PH_RX;
                                step.item.cmd = CMD_RECV;
                            end
                        end
                        PH_RX:
                        begin
                            phase_next          = PH_ACK;
                            step.item.cmd       = CMD_ACK;
                            step.item.ack_value = rx_last;
                            step.item.rx_valid  = 1'b1;
                            step.item.rx_byte   = evt.rx_data;
                        end
                        PH_ACK:
                        begin
                            count_next = count_inc;
                            if (count_inc >= total_reg)
                            begin
                                phase_next    = PH_STOP;
                                step.item.cmd = CMD_STOP;
                            end
                            else
                            begin
                                phase_next    = PH_RX;
                                step.item.cmd = CMD_RECV;
                            end
                        end
                        PH_STOP:
                        begin
                            phase_next           = PH_IDLE;
                            wait_ack_next        = 1'b0;
                            step.item            = '0;
                            step.item.done_res   = 1'b1;
                            step.item.error_code = ERR_OK;
                        end
                        default:
                        begin
                            step = '0;
                        end
                    endcase

                    // A NACK on any sent byte aborts the transaction without a stop.
                    if (!evt.ack_received && (phase_reg == PH_ADDR_W || phase_reg == PH_REG_HI
                        || phase_reg == PH_REG_LO || phase_reg == PH_ADDR_R
                        || (phase_reg == PH_DATA_W && wait_ack_reg)))
                    begin
                        phase_next           = PH_IDLE;
                        wait_ack_next        = 1'b0;
                        count_next           = count_reg;
                        step                 = '0;
                        step.valid           = 1'b1;
                        step.item.done_res   = 1'b1;
                        step.item.error_code = phase_err;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            ticks_reg    <= '0;
            count_reg    <= '0;
            total_reg    <= '0;
            slave_reg    <= '0;
            reg_addr_reg <= '0;
            read_reg     <= 1'b0;
            wait_ack_reg <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            ticks_reg    <= ticks_next;
            count_reg    <= count_next;
            total_reg    <= total_next;
            slave_reg    <= slave_next;
            reg_addr_reg <= reg_addr_next;
            read_reg     <= read_next;
            wait_ack_reg <= wait_ack_next;
        end
    end

endmodule

@@ design/i2crts_out_stage.sv @@
// Result register that drives the output channel and frees itself on each transfer.
// Depends on i2crts_pkg and the i2crts_res_if interface.
`timescale 1ns / 1ps

module i2crts_out_stage
    import i2crts_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  step_t step,
    output logic  space,
    i2crts_res_if.source res
);

    logic      valid_reg, valid_next;
    out_item_t data_reg;

    assign space = !valid_reg || res.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (step.valid)
        begin
            valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step.valid)
        begin
            data_reg <= step.item;
        end
    end

    assign res.valid = valid_reg;
    assign res.data  = data_reg;

endmodule

@@ design/i2c_register_transaction_sequencer_unit.sv @@
// Top level of the I2C register transaction sequencer.
// Depends on i2crts_pkg, the channel interfaces, i2crts_cfg, i2crts_fsm and i2crts_out_stage.
`timescale 1ns / 1ps
// Usage: the evt channel carries requests, write data bytes, bus-done reports
// from the byte-level master engine, and timer ticks. Each transfer on evt
// produces at most one item on the res channel: a bus command for the engine,
// a received byte together with its ACK/NACK command, or a completion with an
// error code. Items that do not apply to the current phase are swallowed.
// A result appears on res in the cycle after the evt transfer that caused it,
// from the result register. Throughput: one evt transfer per cycle unless res
// stalls, since each event is one step of the state machine followed by that register.
// When res is stalled with a result waiting, evt.ready drops until the result
// is taken; a result taken in the same cycle frees the register for the next.
// The configuration port writes the timeout budget and the wide-address slave;
// users must use it only while no transaction is in progress; the block does not check.
// Reset: the sequencer returns to idle with the result register empty, and the
// configuration returns to a budget of 1000 ticks and wide-address slave 0xA0.

`include "i2c_register_transaction_sequencer_unit_macros.svh"

module i2c_register_transaction_sequencer_unit
    import i2crts_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    i2crts_evt_if.sink            evt,
    i2crts_res_if.source          res,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    cfg_t  cfg;
    step_t step;
    logic  space;
    logic  accept;
    logic  busy;

    // An event is taken whenever the result register can absorb what it produces.
    assign evt.ready = space;
    assign accept    = evt.valid && space;

    i2crts_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    i2crts_fsm u_fsm (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .evt    (evt.data),
        .cfg    (cfg),
        .step   (step),
        .busy   (busy)
    );

    i2crts_out_stage u_out (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .space (space),
        .res   (res)
    );

    // A completion never carries a bus command alongside it.
    `I2CRTS_ASSERT_SAME(a_done_no_cmd, clk, rst_n, res.valid && res.data.done_res,
        !res.data.cmd_valid, "completion carries a bus command")
    // A received byte always travels with its ACK/NACK command.
    `I2CRTS_ASSERT_SAME(a_rx_with_ack, clk, rst_n, res.valid && res.data.rx_valid,
        res.data.cmd_valid && res.data.cmd == CMD_ACK, "received byte without ack command")
    // Once a transaction completes or aborts, the sequencer is idle.
    `I2CRTS_ASSERT_NEXT(a_idle_after_done, clk, rst_n, step.valid && step.item.done_res,
        !busy, "sequencer busy after completion")

endmodule
